### hdl/csts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Client/server time sync package
// Shared types, codes and reset values of the remote clock tracker.
// ----------------------------------------------------------------------------
package csts_pkg;

	typedef enum logic {
		CMD_FRAME = 1'b0,
		CMD_FIRST = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ADJ_NONE  = 3'd0,
		ADJ_RESET = 3'd1,
		ADJ_HALVE = 3'd2,
		ADJ_FWD   = 3'd3,
		ADJ_BACK  = 3'd4,
		ADJ_HELD  = 3'd5
	} adj_t;

	typedef enum logic [2:0] {
		REG_RESET_THR = 3'd0,
		REG_FAST_THR  = 3'd1,
		REG_NUDGE     = 3'd2,
		REG_DRIFT_EN  = 3'd3,
		REG_REPLAY    = 3'd4,
		REG_FREEZE    = 3'd5
	} reg_idx_t;

	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [15:0] RESET_THR_RST = 16'd500;
	localparam logic [15:0] FAST_THR_RST  = 16'd100;

	typedef struct packed {
		logic [15:0]       reset_threshold;
		logic [15:0]       fast_threshold;
		logic signed [7:0] time_nudge;
		logic              drift_enabled;
		logic              replay_mode;
		logic              freeze_time;
	} cfg_t;

	typedef struct packed {
		cmd_t        command;
		logic [30:0] local_time;
		logic [30:0] snapshot_time;
		logic        new_snapshot;
		logic        snapshot_inactive;
		logic        paused;
	} item_t;

	typedef struct packed {
		logic signed [31:0] time_offset;
		logic [30:0]        last_output_time;
		logic [30:0]        last_frame_snapshot_time;
		logic               extrapolated_flag;
		logic               active_flag;
	} state_t;

	typedef struct packed {
		logic [30:0]        server_time;
		logic signed [31:0] offset_out;
		adj_t               adjust_kind;
		logic               extrapolating;
		logic               order_error;
		logic               active;
	} result_t;

endpackage

### hdl/client_server_time_sync_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Client/server time sync core
// Tracks a remote server clock from snapshot time stamps, one frame a request.
// ----------------------------------------------------------------------------
// Requests arrive on the in_valid/in_ready channel: a frame tick or the first
// snapshot, with local time, snapshot time and status bits. Every request
// gives exactly one result on the out_valid/out_ready channel: the estimated
// server time, the current offset, the kind of offset adjustment made, and
// the extrapolation, ordering and activity flags.
// A request is captured in an input register and the result is computed
// combinationally into an output register, which raises out_valid; the
// result stays there until out_ready takes it.
// One request is taken every cycle while the receiver does not stall; the
// offset and last output time update as the result is registered.
// When the receiver stalls, the result is held in the output register, the
// captured request waits in the input register, and in_ready falls only once
// both are full. The configuration registers are written through the plain
// write port and should be changed only while no request is in flight.
// Reset clears the tracker to inactive with a zero offset, empties both
// registers and restores the register defaults.
// ----------------------------------------------------------------------------
module client_server_time_sync_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [2:0]                            cfg_index,
	input  logic [csts_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  command,
	input  logic [30:0]                           local_time,
	input  logic [30:0]                           snapshot_time,
	input  logic                                  new_snapshot,
	input  logic                                  snapshot_inactive,
	input  logic                                  paused,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [30:0]                           server_time,
	output logic signed [31:0]                    offset_out,
	output logic [2:0]                            adjust_kind,
	output logic                                  extrapolating,
	output logic                                  order_error,
	output logic                                  active
);

	csts_pkg::cfg_t    cfg;
	csts_pkg::item_t   item_s1;
	logic              valid_s1;
	csts_pkg::state_t  state_q, state_nxt;
	csts_pkg::result_t res_c, res_q;
	logic              out_valid_q;
	logic              advance;

	csts_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	csts_calc u_calc (
		.item (item_s1),
		.cfg  (cfg),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_c)
	);

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.command           <= csts_pkg::cmd_t'(command);
			item_s1.local_time        <= local_time;
			item_s1.snapshot_time     <= snapshot_time;
			item_s1.new_snapshot      <= new_snapshot;
			item_s1.snapshot_inactive <= snapshot_inactive;
			item_s1.paused            <= paused;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_c;
		end
	end

	assign out_valid     = out_valid_q;
	assign server_time   = res_q.server_time;
	assign offset_out    = res_q.offset_out;
	assign adjust_kind   = res_q.adjust_kind;
	assign extrapolating = res_q.extrapolating;
	assign order_error   = res_q.order_error;
	assign active        = res_q.active;

`ifndef SYNTHESIS
	a_active_sticky : assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(state_q.active_flag))
		else $error("active flag dropped");

	a_inactive_quiet : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_q.active) |->
		(res_q.adjust_kind == csts_pkg::ADJ_NONE && !res_q.extrapolating &&
		 !res_q.order_error))
		else $error("inactive result carries frame information");

	a_reset_time : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.adjust_kind == csts_pkg::ADJ_RESET) |->
		(res_q.server_time == state_q.last_output_time &&
		 res_q.offset_out == state_q.time_offset))
		else $error("reset adjustment not reflected in state");

	a_offset_tracks : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.offset_out == state_q.time_offset &&
		 res_q.active == state_q.active_flag))
		else $error("result offset differs from state");
`endif

endmodule

### hdl/csts_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time sync configuration registers
// Holds the thresholds, nudge and mode bits written through the write port.
// ----------------------------------------------------------------------------
module csts_cfg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [2:0]                            cfg_index,
	input  logic [csts_pkg::CFG_DATA_W-1:0]       cfg_data,
	output csts_pkg::cfg_t                        cfg
);

	csts_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_threshold <= csts_pkg::RESET_THR_RST;
			cfg_q.fast_threshold  <= csts_pkg::FAST_THR_RST;
			cfg_q.time_nudge      <= 8'sd0;
			cfg_q.drift_enabled   <= 1'b1;
			cfg_q.replay_mode     <= 1'b0;
			cfg_q.freeze_time     <= 1'b0;
		end else if (cfg_we) begin
			unique case (csts_pkg::reg_idx_t'(cfg_index))
				csts_pkg::REG_RESET_THR: cfg_q.reset_threshold <= cfg_data;
				csts_pkg::REG_FAST_THR:  cfg_q.fast_threshold  <= cfg_data;
				csts_pkg::REG_NUDGE:     cfg_q.time_nudge      <= cfg_data[7:0];
				csts_pkg::REG_DRIFT_EN:  cfg_q.drift_enabled   <= cfg_data[0];
				csts_pkg::REG_REPLAY:    cfg_q.replay_mode     <= cfg_data[0];
				csts_pkg::REG_FREEZE:    cfg_q.freeze_time     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hdl/csts_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time sync frame calculation
// Works out the next tracker state and the result for one request.
// ----------------------------------------------------------------------------
module csts_calc (
	input  csts_pkg::item_t   item,
	input  csts_pkg::cfg_t    cfg,
	input  csts_pkg::state_t  cur,
	output csts_pkg::state_t  nxt,
	output csts_pkg::result_t res
);

	localparam logic signed [33:0] T31_MAX  = 34'sh0_7FFF_FFFF;
	localparam logic signed [33:0] S32_MAX  = 34'sh0_7FFF_FFFF;
	localparam logic signed [33:0] S32_MIN  = -34'sh0_8000_0000;
	localparam logic signed [7:0]  NUDGE_HI = 8'sd30;
	localparam logic signed [7:0]  NUDGE_LO = -8'sd30;
	localparam logic signed [33:0] NEAR_MARGIN = 34'sd5;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX) begin
			r = S32_MAX[31:0];
		end else if (v < S32_MIN) begin
			r = S32_MIN[31:0];
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	logic signed [33:0] loc_w, snap_w, off_w, nudge_w;
	logic signed [33:0] base_w, raw_w, nd_w, diff_w, abs_w, hsum_w;
	logic signed [7:0]  nudge_c;
	logic [30:0]        clamp_t, mono_t, st;
	logic               near, extr, oerr, ext_nxt;
	csts_pkg::adj_t     kind;

	always_comb begin
		loc_w  = {3'b000, item.local_time};
		snap_w = {3'b000, item.snapshot_time};
		off_w  = {{2{cur.time_offset[31]}}, cur.time_offset};

		if (cfg.time_nudge > NUDGE_HI) begin
			nudge_c = NUDGE_HI;
		end else if (cfg.time_nudge < NUDGE_LO) begin
			nudge_c = NUDGE_LO;
		end else begin
			nudge_c = cfg.time_nudge;
		end
		nudge_w = {{26{nudge_c[7]}}, nudge_c};

		base_w = loc_w + off_w;
		raw_w  = base_w - nudge_w;
		if (raw_w < 34'sd0) begin
			clamp_t = '0;
		end else if (raw_w > T31_MAX) begin
			clamp_t = T31_MAX[30:0];
		end else begin
			clamp_t = raw_w[30:0];
		end
		mono_t = (clamp_t < cur.last_output_time) ? cur.last_output_time : clamp_t;
		near   = base_w >= (snap_w - NEAR_MARGIN);

		nd_w   = snap_w - loc_w;
		diff_w = nd_w - off_w;
		abs_w  = diff_w[33] ? -diff_w : diff_w;
		hsum_w = off_w + nd_w;
	end

	always_comb begin
		nxt     = cur;
		st      = cur.last_output_time;
		kind    = csts_pkg::ADJ_NONE;
		extr    = 1'b0;
		oerr    = 1'b0;
		ext_nxt = cur.extrapolated_flag;

		if (item.command == csts_pkg::CMD_FIRST) begin
			if (!item.snapshot_inactive && !cur.active_flag) begin
				nxt.active_flag      = 1'b1;
				nxt.time_offset      = nd_w[31:0];
				nxt.last_output_time = item.snapshot_time;
				st                   = item.snapshot_time;
			end
		end else if (cur.active_flag && !item.paused) begin
			oerr = item.snapshot_time < cur.last_frame_snapshot_time;
			nxt.last_frame_snapshot_time = item.snapshot_time;

			if (!(cfg.replay_mode && cfg.freeze_time)) begin
				st                   = mono_t;
				nxt.last_output_time = mono_t;
				if (near) begin
					ext_nxt = 1'b1;
					extr    = 1'b1;
				end
			end

			if (item.new_snapshot && !cfg.replay_mode) begin
				if (abs_w > {18'd0, cfg.reset_threshold}) begin
					nxt.time_offset      = nd_w[31:0];
					nxt.last_output_time = item.snapshot_time;
					st                   = item.snapshot_time;
					kind                 = csts_pkg::ADJ_RESET;
				end else if (abs_w > {18'd0, cfg.fast_threshold}) begin
					nxt.time_offset = sat32(hsum_w >>> 1);
					kind            = csts_pkg::ADJ_HALVE;
				end else if (cfg.drift_enabled) begin
					if (ext_nxt) begin
						ext_nxt         = 1'b0;
						nxt.time_offset = sat32(off_w - 34'sd2);
						kind            = csts_pkg::ADJ_BACK;
					end else begin
						nxt.time_offset = sat32(off_w + 34'sd1);
						kind            = csts_pkg::ADJ_FWD;
					end
				end else begin
					kind = csts_pkg::ADJ_HELD;
				end
			end
			nxt.extrapolated_flag = ext_nxt;
		end

		res.server_time   = st;
		res.offset_out    = nxt.time_offset;
		res.adjust_kind   = kind;
		res.extrapolating = extr;
		res.order_error   = oerr;
		res.active        = nxt.active_flag;
	end

endmodule
